// ===== rtl/trem_pkg.sv =====
// ----------------------------------------------------------------------------
// Tremolo package
// Shared constants, codes, types and the quarter-wave sine table builder for
// the tremolo amplitude modulator.
// ----------------------------------------------------------------------------
package trem_pkg;

  // Sizes. The sine table depth is a power of two.
  localparam int unsigned SINE_TABLE_DEPTH = 256;
  localparam int unsigned PHASE_BITS       = 32;
  localparam int unsigned SAMPLE_BITS      = 24;

  localparam int unsigned TAB_BITS  = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned STEP_BITS = 31;
  localparam int unsigned DEPTH_BITS = 16;
  localparam int unsigned WAVE_BITS = 2;
  localparam int unsigned CFG_DATA_BITS = 31;
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned Q15_BITS = 16;
  localparam int unsigned PROD_BITS = SAMPLE_BITS + Q15_BITS;

  // Q1.15 constants.
  localparam logic [Q15_BITS-1:0] Q15_ONE  = 16'd32768;
  localparam logic [Q15_BITS-1:0] Q15_HALF = 16'd16384;

  // Reset values of the configuration registers.
  localparam logic [STEP_BITS-1:0]  PHASE_STEP_RESET = 31'd42950;
  localparam logic [DEPTH_BITS-1:0] MOD_DEPTH_RESET  = 16'd16384;

  // pi/2 in Q30.
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PHASE_STEP = 2'd0,
    REG_MOD_DEPTH  = 2'd1,
    REG_WAVEFORM   = 2'd2
  } trem_reg_t;

  typedef enum logic [WAVE_BITS-1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_TRI    = 2'd1,
    WAVE_SQUARE = 2'd2
  } trem_wave_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GAIN,
    ST_SCALE
  } trem_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;   // capture the sample and LFO value, advance the phase
    logic do_gain;   // multiplier forms depth*lfo, gain register loads
    logic load_out;  // multiplier forms mag*gain, output register loads
  } trem_cmd_t;

  // Quarter-wave sine entry k: round(16384*sin(k*pi/(2*DEPTH))), from an
  // eight-term integer Taylor series in Q30. Only evaluated with constant k.
  function automatic logic [Q15_BITS-2:0] quarter_sine(input int unsigned k);
    longint unsigned ang;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint unsigned v;
    ang  = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
    x2   = (ang * ang) >> 30;
    term = ang;
    sum  = longint'(ang);
    term = ((term * x2) >> 30) / 6;   sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 20;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 42;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 72;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 110; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 156; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 210; sum = sum - longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    v = (longint'(sum) * 16384 + (64'd1 << 29)) >> 30;
    if (v > 16384) begin
      v = 16384;
    end
    return (Q15_BITS-1)'(v);
  endfunction

endpackage

// ===== rtl/trem_ctrl.sv =====
// ----------------------------------------------------------------------------
// Tremolo controller
// Sequences one word through the LFO, gain and scale steps and owns the
// output valid flag.
// ----------------------------------------------------------------------------
module trem_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output trem_pkg::trem_cmd_t cmd
);

  trem_pkg::trem_state_t state;
  trem_pkg::trem_state_t state_next;
  logic                  out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= trem_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.load_in  = 1'b0;
    cmd.do_gain  = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state)
      trem_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_next = trem_pkg::ST_GAIN;
        end
      end
      trem_pkg::ST_GAIN: begin
        cmd.do_gain = 1'b1;
        state_next  = trem_pkg::ST_SCALE;
      end
      trem_pkg::ST_SCALE: begin
        // Wait here while the previous result is still unclaimed.
        cmd.load_out = !out_valid || out_ready;
        if (cmd.load_out) begin
          state_next = trem_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = trem_pkg::ST_IDLE;
      end
    endcase

    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == trem_pkg::ST_GAIN))
    else $error("accepted word did not start the gain step");

  a_gain_then_scale: assert property (@(posedge clk) disable iff (rst)
    (state == trem_pkg::ST_GAIN) |=> (state == trem_pkg::ST_SCALE))
    else $error("gain step not followed by scale step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("output register loaded over an unclaimed result");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

endmodule

// ===== rtl/trem_dpath.sv =====
// ----------------------------------------------------------------------------
// Tremolo datapath
// Configuration registers, LFO phase accumulator and waveform generator, one
// shared multiplier for the gain and the scaled sample, and the output
// register.
// ----------------------------------------------------------------------------
module trem_dpath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [trem_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [trem_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic signed [trem_pkg::SAMPLE_BITS-1:0] sample_in,
  input  trem_pkg::trem_cmd_t                   cmd,
  output logic signed [trem_pkg::SAMPLE_BITS-1:0] sample_out
);

  localparam int unsigned PB = trem_pkg::PHASE_BITS;
  localparam int unsigned SB = trem_pkg::SAMPLE_BITS;
  localparam int unsigned QB = trem_pkg::Q15_BITS;
  localparam int unsigned TB = trem_pkg::TAB_BITS;
  localparam int unsigned PW = trem_pkg::PROD_BITS;

  // Configuration and phase state.
  logic [trem_pkg::STEP_BITS-1:0]  phase_step;
  logic [trem_pkg::DEPTH_BITS-1:0] mod_depth;
  logic [trem_pkg::WAVE_BITS-1:0]  waveform;
  logic [PB-1:0]                   lfo_phase;
  logic [PB-1:0]                   lfo_phase_next;

  // Per-word working registers.
  logic          neg;
  logic [SB-1:0] mag;
  logic [QB-1:0] lfo;
  logic [QB-1:0] lfo_next;
  logic [QB-1:0] gain;

  // Quarter-wave table, a constant built at elaboration.
  logic [QB-2:0] qtab [trem_pkg::SINE_TABLE_DEPTH];

  for (genvar k = 0; k < trem_pkg::SINE_TABLE_DEPTH; k++) begin : g_qtab
    assign qtab[k] = trem_pkg::quarter_sine(k);
  end

  logic [1:0]    quad;
  logic [TB-1:0] tab_off;
  logic [TB-1:0] tab_addr;
  logic [QB-2:0] tab_val;
  logic [QB-1:0] tri_top;
  logic [PB-1:0] full_inc;
  logic [PB-1:0] half_inc;

  always_comb begin
    quad     = lfo_phase[PB-1 -: 2];
    tab_off  = lfo_phase[PB-3 -: TB];
    // Odd quadrants run the table backwards; their first entry is the peak.
    tab_addr = quad[0] ? (TB'(0) - tab_off) : tab_off;
    if (quad[0] && (tab_off == '0)) begin
      tab_val = (QB-1)'(trem_pkg::Q15_HALF);
    end else begin
      tab_val = qtab[tab_addr];
    end
    tri_top  = lfo_phase[PB-1 -: QB];
    full_inc = PB'(phase_step);
    half_inc = PB'(phase_step >> 1);

    unique case (waveform)
      trem_pkg::WAVE_SINE: begin
        lfo_next = quad[1] ? (trem_pkg::Q15_HALF - QB'(tab_val))
                           : (trem_pkg::Q15_HALF + QB'(tab_val));
        lfo_phase_next = lfo_phase + full_inc;
      end
      trem_pkg::WAVE_TRI: begin
        lfo_next = (tri_top >= trem_pkg::Q15_ONE) ? (tri_top - trem_pkg::Q15_ONE)
                                                  : (trem_pkg::Q15_ONE - tri_top);
        lfo_phase_next = lfo_phase + half_inc;
      end
      trem_pkg::WAVE_SQUARE: begin
        lfo_next = lfo_phase[PB-1] ? '0 : trem_pkg::Q15_ONE;
        lfo_phase_next = lfo_phase + half_inc;
      end
      default: begin
        // Unused code: no modulation and the phase holds.
        lfo_next       = '0;
        lfo_phase_next = lfo_phase;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= trem_pkg::PHASE_STEP_RESET;
      mod_depth  <= trem_pkg::MOD_DEPTH_RESET;
      waveform   <= trem_pkg::WAVE_SINE;
      lfo_phase  <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          trem_pkg::REG_PHASE_STEP: phase_step <= cfg_data;
          trem_pkg::REG_MOD_DEPTH:  mod_depth  <= cfg_data[trem_pkg::DEPTH_BITS-1:0];
          trem_pkg::REG_WAVEFORM:   waveform   <= cfg_data[trem_pkg::WAVE_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd.load_in) begin
        lfo_phase <= lfo_phase_next;
      end
    end
  end

  // Shared multiplier: depth*lfo in the gain step, |sample|*gain in the
  // scale step. Both products are rounded by adding one half LSB.
  logic [QB-1:0] depth_sat;
  logic [SB-1:0] mult_a;
  logic [QB-1:0] mult_b;
  logic [PW-1:0] prod;
  logic [PW-1:0] prod_rnd;
  logic [QB-1:0] gain_next;
  logic [SB-1:0] mag_scaled;
  logic [SB-1:0] res;

  always_comb begin
    depth_sat  = (mod_depth > trem_pkg::Q15_ONE) ? trem_pkg::Q15_ONE : mod_depth;
    mult_a     = cmd.do_gain ? SB'(depth_sat) : mag;
    mult_b     = cmd.do_gain ? lfo : gain;
    prod       = PW'(mult_a) * PW'(mult_b);
    prod_rnd   = prod + PW'(trem_pkg::Q15_HALF);
    gain_next  = trem_pkg::Q15_ONE - prod_rnd[QB+14:15];
    mag_scaled = prod_rnd[SB+14:15];
    res        = neg ? (SB'(0) - mag_scaled) : mag_scaled;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      neg <= sample_in[SB-1];
      mag <= sample_in[SB-1] ? (SB'(0) - SB'(sample_in)) : SB'(sample_in);
      lfo <= lfo_next;
    end
    if (cmd.do_gain) begin
      gain <= gain_next;
    end
    if (cmd.load_out) begin
      sample_out <= signed'(res);
    end
  end

endmodule

// ===== rtl/tremolo_lfo_amplitude_modulator.sv =====
// ----------------------------------------------------------------------------
// Tremolo LFO amplitude modulator
// Scales each signed audio word by the gain 1 - depth*lfo, where the LFO is a
// sine, triangle or square wave driven by a phase accumulator.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                          Direction  Width
//  input     in_valid, in_ready, sample_in    in         24 signed
//  output    out_valid, out_ready, sample_out out        24 signed
//  config    cfg_write, cfg_index, cfg_data   in         2 / 31
//
// A word is accepted in the idle state; the shared multiplier forms the gain
// in the next cycle, in the gain step, and then the scaled sample in the scale
// step, which loads the output register. The single multiplier is used twice
// per word. The next word is accepted while a result still waits in the
// output register; a result that finds that register full waits in the scale
// step. Reset is synchronous and restores the register defaults and a zero
// LFO phase.
//
// The LFO value is taken from the current phase before the phase advances.
// Triangle and square advance by half the programmed step, sine by the full
// step; the phase wraps modulo one LFO period. Depth values above full scale
// act as full scale. The unused waveform code passes the sample unchanged and
// holds the phase. Write configuration only while idle; this is not enforced.
// ----------------------------------------------------------------------------
module tremolo_lfo_amplitude_modulator (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [trem_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [trem_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [trem_pkg::SAMPLE_BITS-1:0] sample_in,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [trem_pkg::SAMPLE_BITS-1:0] sample_out
);

  // Command bundle from the sequencer to the datapath.
  trem_pkg::trem_cmd_t cmd;

  // The controller steps each word through its idle, gain and scale steps and tracks
  // whether the output register holds an unclaimed result.
  trem_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // The datapath holds the configuration, the phase accumulator, the
  // waveform generator, the shared multiplier and the output register.
  trem_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (sample_in),
    .cmd        (cmd),
    .sample_out (sample_out)
  );

endmodule
